// ===== rtl/core/sks_pkg.sv =====
// Shared types, constants and helpers for the sorted key table search unit.
package sks_pkg;

    localparam int DEPTH     = 64;
    localparam int KEY_BYTES = 8;

    localparam int KEY_W   = 64;
    localparam int TAG_W   = 10;
    localparam int OP_W    = 2;
    localparam int PLEN_W  = 4;
    localparam int STAT_W  = 2;
    localparam int POS_W   = 6;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ENTRY_W = KEY_W + TAG_W;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_EXACT  = 2'd1;
    localparam logic [OP_W-1:0] OP_PREFIX = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;          // latch operands, set up search bounds and index
        logic clear;         // empty the table and report done
        logic emit_full;     // report table full
        logic ins_shift;     // move entry at idx up one slot, step idx down
        logic ins_place;     // write the new entry at idx + 1 and report it
        logic probe_issue;   // read the middle entry of the bounds
        logic probe_lo;      // raise the low bound past the probe
        logic probe_hi;      // drop the high bound to just below the probe
        logic emit_found;    // report the probed entry as an exact hit
        logic emit_nf;       // report not found
        logic hit_prefix;    // hold the probed entry as pending, start upward scan
        logic scan_up_step;  // report pending, hold current, step idx up
        logic scan_turn;     // restart the scan just below the first hit
        logic scan_dn_step;  // report pending, hold current, step idx down
        logic emit_final;    // report pending as the last result
    } sks_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;        // table holds DEPTH entries
        logic probe_more;  // search bounds are not empty
        logic eq;          // masked stored key equals the masked search key
        logic gt;          // masked stored key is above the masked search key
        logic ins_move;    // stored entry is valid and above the new key
        logic scan_match;  // stored entry is valid and matches the prefix
    } sks_stat_t;

    // Mask keeping the leading nb key bytes, limited to KEY_BYTES.
    function automatic logic [KEY_W-1:0] top_mask(input logic [PLEN_W-1:0] nb);
        logic [KEY_W-1:0]  m;
        logic [PLEN_W-1:0] lim;
        lim = (nb > PLEN_W'(KEY_BYTES)) ? PLEN_W'(KEY_BYTES) : nb;
        m   = '0;
        for (int b = 0; b < KEY_W / 8; b++) begin
            if (PLEN_W'(b) < lim)
            begin
                m[KEY_W-1-8*b -: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    localparam logic [KEY_W-1:0] KEY_MASK = top_mask(PLEN_W'(KEY_BYTES));

endpackage

// ===== rtl/core/sks_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/sks_ctrl.sv =====
// Controller state machine for the sorted key table search unit.
module sks_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [sks_pkg::OP_W-1:0] op,
    input  sks_pkg::sks_stat_t       stat,
    output sks_pkg::sks_cmd_t        cmd,
    output logic                     busy
);
    import sks_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INS   = 3'd1;
    localparam logic [2:0] S_PROBE = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_UP    = 3'd4;
    localparam logic [2:0] S_DN    = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       prefix_reg, prefix_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        prefix_next = prefix_reg;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (op == OP_CLEAR)
                    begin
                        cmd.clear = 1'b1;
                    end
                    else
                    begin
                        cmd.load    = 1'b1;
                        prefix_next = (op == OP_PREFIX);
                        state_next  = (op == OP_INSERT) ? S_INS : S_PROBE;
                    end
                end
            end
            S_INS:
            begin
                if (stat.full)
                begin
                    cmd.emit_full = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (stat.ins_move)
                begin
                    cmd.ins_shift = 1'b1;
                end
                else
                begin
                    cmd.ins_place = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_PROBE:
            begin
                if (stat.probe_more)
                begin
                    cmd.probe_issue = 1'b1;
                    state_next      = S_CMP;
                end
                else
                begin
                    cmd.emit_nf = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_CMP:
            begin
                if (stat.eq)
                begin
                    if (prefix_reg)
                    begin
                        cmd.hit_prefix = 1'b1;
                        state_next     = S_UP;
                    end
                    else
                    begin
                        cmd.emit_found = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    cmd.probe_hi = stat.gt;
                    cmd.probe_lo = !stat.gt;
                    state_next   = S_PROBE;
                end
            end
            S_UP:
            begin
                if (stat.scan_match)
                begin
                    cmd.scan_up_step = 1'b1;
                end
                else
                begin
                    cmd.scan_turn = 1'b1;
                    state_next    = S_DN;
                end
            end
            S_DN:
            begin
                if (stat.scan_match)
                begin
                    cmd.scan_dn_step = 1'b1;
                end
                else
                begin
                    cmd.emit_final = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            prefix_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            prefix_reg <= prefix_next;
        end
    end

endmodule

// ===== rtl/core/sks_datapath.sv =====
// Datapath: entry memory, count, search bounds, scan index and result registers.
module sks_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [sks_pkg::KEY_W-1:0]  key,
    input  logic [sks_pkg::TAG_W-1:0]  tag,
    input  logic [sks_pkg::PLEN_W-1:0] prefix_len,
    input  logic [sks_pkg::OP_W-1:0]   op,
    input  sks_pkg::sks_cmd_t          cmd,
    output sks_pkg::sks_stat_t         stat,
    output logic                       done,
    output logic [sks_pkg::STAT_W-1:0] status,
    output logic [sks_pkg::TAG_W-1:0]  entry_tag,
    output logic [sks_pkg::POS_W-1:0]  position,
    output logic                       last
);
    import sks_pkg::*;

    logic [KEY_W-1:0]   key_reg, key_next;
    logic [TAG_W-1:0]   tag_reg, tag_next;
    logic [KEY_W-1:0]   mask_reg, mask_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   lo_reg, lo_next;
    logic [CNT_W-1:0]   hi_reg, hi_next;     // one past the high bound
    logic [CNT_W-1:0]   mid_reg, mid_next;
    logic [TAG_W-1:0]   pend_tag_reg, pend_tag_next;
    logic [CNT_W-1:0]   pend_pos_reg, pend_pos_next;

    logic               done_reg, done_next;
    logic [STAT_W-1:0]  status_reg, status_next;
    logic [TAG_W-1:0]   etag_reg, etag_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               last_reg, last_next;

    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [ENTRY_W-1:0] rdata;
    logic [KEY_W-1:0]   rd_key;
    logic [TAG_W-1:0]   rd_tag;
    logic [KEY_W-1:0]   have, want;
    logic [CNT_W:0]     bound_sum;
    logic [CNT_W-1:0]   probe_mid;
    logic [CNT_W-1:0]   idx_up;
    logic               idx_valid;

    // rdata always holds the entry at idx_reg: the read address is the next index
    sks_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (idx_next[ADDR_W-1:0]),
        .rdata (rdata)
    );

    assign rd_key    = rdata[ENTRY_W-1 -: KEY_W];
    assign rd_tag    = rdata[TAG_W-1:0];
    assign have      = rd_key & mask_reg;
    assign want      = key_reg & mask_reg;
    assign idx_up    = idx_reg + CNT_W'(1);
    // an index below zero wraps to all ones and so fails this check too
    assign idx_valid = (idx_reg < count_reg);
    assign bound_sum = {1'b0, lo_reg} + {1'b0, hi_reg} - (CNT_W + 1)'(1);
    assign probe_mid = bound_sum[CNT_W:1];

    assign stat.full       = (count_reg == CNT_W'(DEPTH));
    assign stat.probe_more = (lo_reg < hi_reg);
    assign stat.eq         = (have == want);
    assign stat.gt         = (have > want);
    assign stat.ins_move   = idx_valid && (want < have);
    assign stat.scan_match = idx_valid && (have == want);

    assign waddr = idx_up[ADDR_W-1:0];
    assign wdata = cmd.ins_place ? {key_reg, tag_reg} : rdata;
    assign we    = cmd.ins_shift || cmd.ins_place;

    always_comb
    begin
        key_next      = key_reg;
        tag_next      = tag_reg;
        mask_next     = mask_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        pend_tag_next = pend_tag_reg;
        pend_pos_next = pend_pos_reg;
        done_next     = 1'b0;
        status_next   = ST_DONE;
        etag_next     = '0;
        pos_next      = '0;
        last_next     = 1'b1;

        if (cmd.load)
        begin
            key_next  = key & KEY_MASK;
            tag_next  = tag;
            mask_next = (op == OP_PREFIX) ? top_mask(prefix_len) : KEY_MASK;
            lo_next   = '0;
            hi_next   = count_reg;
            idx_next  = count_reg - CNT_W'(1);
        end
        if (cmd.clear)
        begin
            count_next = '0;
            done_next  = 1'b1;
        end
        if (cmd.emit_full)
        begin
            done_next   = 1'b1;
            status_next = ST_FULL;
        end
        if (cmd.emit_nf)
        begin
            done_next   = 1'b1;
            status_next = ST_NOTFOUND;
        end
        if (cmd.ins_shift)
        begin
            idx_next = idx_reg - CNT_W'(1);
        end
        if (cmd.ins_place)
        begin
            count_next = count_reg + CNT_W'(1);
            done_next  = 1'b1;
            etag_next  = tag_reg;
            pos_next   = POS_W'(idx_up);
        end
        if (cmd.probe_issue)
        begin
            idx_next = probe_mid;
        end
        if (cmd.probe_lo)
        begin
            lo_next = idx_up;
        end
        if (cmd.probe_hi)
        begin
            hi_next = idx_reg;
        end
        if (cmd.emit_found)
        begin
            done_next = 1'b1;
            etag_next = rd_tag;
            pos_next  = POS_W'(idx_reg);
        end
        if (cmd.hit_prefix)
        begin
            pend_tag_next = rd_tag;
            pend_pos_next = idx_reg;
            mid_next      = idx_reg;
            idx_next      = idx_up;
        end
        if (cmd.scan_up_step || cmd.scan_dn_step || cmd.emit_final)
        begin
            done_next = 1'b1;
            etag_next = pend_tag_reg;
            pos_next  = POS_W'(pend_pos_reg);
            last_next = cmd.emit_final;
        end
        if (cmd.scan_up_step || cmd.scan_dn_step)
        begin
            pend_tag_next = rd_tag;
            pend_pos_next = idx_reg;
        end
        if (cmd.scan_up_step)
        begin
            idx_next = idx_up;
        end
        if (cmd.scan_turn)
        begin
            idx_next = mid_reg - CNT_W'(1);
        end
        if (cmd.scan_dn_step)
        begin
            idx_next = idx_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        tag_reg      <= tag_next;
        mask_reg     <= mask_next;
        idx_reg      <= idx_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        pend_tag_reg <= pend_tag_next;
        pend_pos_reg <= pend_pos_next;
        status_reg   <= status_next;
        etag_reg     <= etag_next;
        pos_reg      <= pos_next;
        last_reg     <= last_next;
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign entry_tag = etag_reg;
    assign position  = pos_reg;
    assign last      = last_reg;

endmodule

// ===== rtl/core/sorted_key_table_search_unit.sv =====
// Top level of the sorted key table search unit: controller plus datapath.
//
// A transaction is taken when start is high and busy is low; each result
// appears for one cycle with done high and must be captured then, and last
// marks the final result of a transaction. Clear keeps busy low and reports
// in the next cycle. Insert walks down from the top entry through the single
// read port of the entry RAM, moving each entry above the new key up one
// slot before writing the new entry. Exact search is a binary search, and a
// probe waits on its registered RAM read before the next bound is known.
// Prefix search runs the same probes, then scans up and then down from the
// first hit, one result per cycle while the scan runs, except at the turn
// from the upward to the downward scan.
module sorted_key_table_search_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [sks_pkg::OP_W-1:0]   op,
    input  logic [sks_pkg::KEY_W-1:0]  key,
    input  logic [sks_pkg::TAG_W-1:0]  tag,
    input  logic [sks_pkg::PLEN_W-1:0] prefix_len,
    output logic                       done,
    output logic [sks_pkg::STAT_W-1:0] status,
    output logic [sks_pkg::TAG_W-1:0]  entry_tag,
    output logic [sks_pkg::POS_W-1:0]  position,
    output logic                       last
);
    import sks_pkg::*;

    sks_cmd_t  cmd;
    sks_stat_t stat;

    sks_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    sks_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .key        (key),
        .tag        (tag),
        .prefix_len (prefix_len),
        .op         (op),
        .cmd        (cmd),
        .stat       (stat),
        .done       (done),
        .status     (status),
        .entry_tag  (entry_tag),
        .position   (position),
        .last       (last)
    );

endmodule
